// ===== rtl/shabs_pkg.sv =====
// shared types, constants and round functions for the sha-256 byte stream hasher
`default_nettype none

package shabs_pkg;

    localparam int unsigned HASH_WORDS = 8;
    localparam int unsigned ROUNDS     = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_H [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // control toward the round unit
    typedef struct packed {
        logic iv;     // load initial hash values
        logic load;   // working vars <= hash state
        logic rnd;    // one compression round
        logic add;    // hash state += working vars
    } round_ctl_t;

    // control toward the schedule window
    typedef struct packed {
        logic byte_en;    // shift a byte into the word assembler
        logic word_done;  // this byte completes a word
        logic adv;        // produce the next schedule word
        logic raw;        // next word comes straight from the window
    } sched_ctl_t;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/shabs_sched.sv =====
// byte-to-word assembler and 16-word message schedule shift window
`default_nettype none

module shabs_sched (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire shabs_pkg::sched_ctl_t ctl,
    input  wire logic [7:0]            byte_in,
    output logic [31:0]                w_word
);

    logic [23:0] asm_reg;
    logic [31:0] win_reg [16];
    logic [31:0] w_reg;
    logic [31:0] w_next;
    logic [31:0] push_word;

    assign push_word = {asm_reg, byte_in};

    // win_reg[0] is the oldest word, w[t-16] for a computed word
    always_comb
    begin
        if (ctl.raw)
        begin
            w_next = win_reg[0];
        end
        else
        begin
            w_next = shabs_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                   + shabs_pkg::small_sigma0(win_reg[1]) + win_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else if (ctl.adv)
        begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.byte_en)
        begin
            asm_reg <= {asm_reg[15:0], byte_in};
        end
        if (ctl.byte_en && ctl.word_done)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= push_word;
        end
        else if (ctl.adv)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_next;
        end
    end

    assign w_word = w_reg;

endmodule

`default_nettype wire

// ===== rtl/shabs_round.sv =====
// shared compression round unit with working variables and hash state
`default_nettype none

module shabs_round (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire shabs_pkg::round_ctl_t ctl,
    input  wire logic [31:0]           k_word,
    input  wire logic [31:0]           w_word,
    input  wire logic [2:0]            rd_idx,
    output logic [31:0]                hash_word
);

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + shabs_pkg::big_sigma1(v_reg[4]) + ch + k_word + w_word;
    assign t2  = shabs_pkg::big_sigma0(v_reg[0]) + maj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= shabs_pkg::INIT_H[i];
                v_reg[i] <= '0;
            end
        end
        else if (ctl.iv)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= shabs_pkg::INIT_H[i];
            end
        end
        else if (ctl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (ctl.rnd)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (ctl.add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign hash_word = h_reg[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher_core.sv =====
// top level of the sha-256 byte stream hasher: sequencer, padding and digest output
// usage
//   input channel (in_valid/in_ready): one item per handshake; byte_present
//   says whether data_byte is a message byte, message_end closes the message
//   output channel (out_valid/out_ready): eight items per message, the digest
//   words h0..h7 with word_index 0..7 and last_word set on the eighth
// flow
//   a byte item is taken at each handshake while a block is being collected
//   the 64th byte of a block starts compression: the working vars are
//   loaded, 64 rounds run on the one shared round unit, then the hash
//   state is updated, all with in_ready low
//   at message end the padding is generated one byte per cycle into the same
//   block path (over up to two blocks, paused for a compression after each),
//   then the digest is offered one word per accepted cycle
// reset
//   asynchronous, active low; leaves the hasher empty with the initial hash
//   values loaded, in_ready high and out_valid low
// stalls
//   while out_ready is low the current digest word holds and no new item is
//   taken; the next message starts only after the last word is delivered
`default_nettype none

module sha256_byte_stream_hasher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        byte_present,
    input  wire logic [7:0]  data_byte,
    input  wire logic        message_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_PAD     = 3'd1;
    localparam logic [2:0] ST_PRIME   = 3'd2;
    localparam logic [2:0] ST_ROUND   = 3'd3;
    localparam logic [2:0] ST_ADD     = 3'd4;
    localparam logic [2:0] ST_OUT     = 3'd5;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] RAW_LAST  = 6'd15;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;         // bytes in the current block
    logic [63:0] bit_count_reg, bit_count_next;
    logic [5:0]  round_cnt_reg, round_cnt_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pend_end_reg, pend_end_next; // message end seen, padding owed
    logic        pad80_reg, pad80_next;       // pad marker already written
    logic        len_reg, len_next;           // writing the length field
    logic        final_reg, final_next;       // block in flight is the last one

    shabs_pkg::round_ctl_t rctl;
    shabs_pkg::sched_ctl_t sctl;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    logic [7:0]  len_byte;
    logic [63:0] len_shift;
    logic        is_len;
    logic [31:0] w_word;
    logic [31:0] hash_word;

    // length field goes out big-endian, byte k of it at block offset 56 + k
    assign len_shift = bit_count_reg << {fill_reg[2:0], 3'b000};
    assign len_byte  = len_shift[63:56];
    assign is_len    = pad80_reg && (len_reg || (fill_reg == LEN_POS));

    always_comb
    begin
        if (!pad80_reg)
        begin
            pad_byte = shabs_pkg::PAD_BYTE;
        end
        else if (is_len)
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_count_next = bit_count_reg;
        round_cnt_next = round_cnt_reg;
        out_idx_next   = out_idx_reg;
        pend_end_next  = pend_end_reg;
        pad80_next     = pad80_reg;
        len_next       = len_reg;
        final_next     = final_reg;
        rctl           = '0;
        sctl           = '0;
        push_byte      = data_byte;

        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    pend_end_next = message_end;
                    if (byte_present)
                    begin
                        sctl.byte_en   = 1'b1;
                        bit_count_next = bit_count_reg + 64'd8;
                        fill_next      = fill_reg + 6'd1;
                        if (fill_reg == LAST_POS)
                        begin
                            state_next = ST_PRIME;
                        end
                        else if (message_end)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (message_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                sctl.byte_en = 1'b1;
                push_byte    = pad_byte;
                fill_next    = fill_reg + 6'd1;
                pad80_next   = 1'b1;
                if (is_len)
                begin
                    len_next = 1'b1;
                end
                if (fill_reg == LAST_POS)
                begin
                    state_next = ST_PRIME;
                    final_next = is_len;
                end
            end
            ST_PRIME:
            begin
                rctl.load      = 1'b1;
                sctl.adv       = 1'b1;
                sctl.raw       = 1'b1;
                round_cnt_next = '0;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                rctl.rnd       = 1'b1;
                sctl.adv       = 1'b1;
                sctl.raw       = (round_cnt_reg < RAW_LAST);
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == LAST_POS)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                rctl.add = 1'b1;
                if (final_reg)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end
                else if (pend_end_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_COLLECT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        // back to an empty message
                        rctl.iv        = 1'b1;
                        fill_next      = '0;
                        bit_count_next = '0;
                        pend_end_next  = 1'b0;
                        pad80_next     = 1'b0;
                        len_next       = 1'b0;
                        final_next     = 1'b0;
                        state_next     = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase

        sctl.word_done = (fill_reg[1:0] == 2'b11);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            fill_reg      <= '0;
            bit_count_reg <= '0;
            round_cnt_reg <= '0;
            out_idx_reg   <= '0;
            pend_end_reg  <= 1'b0;
            pad80_reg     <= 1'b0;
            len_reg       <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_count_reg <= bit_count_next;
            round_cnt_reg <= round_cnt_next;
            out_idx_reg   <= out_idx_next;
            pend_end_reg  <= pend_end_next;
            pad80_reg     <= pad80_next;
            len_reg       <= len_next;
            final_reg     <= final_next;
        end
    end

    shabs_sched u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sctl),
        .byte_in (push_byte),
        .w_word  (w_word)
    );

    shabs_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rctl),
        .k_word    (shabs_pkg::ROUND_K[round_cnt_reg]),
        .w_word    (w_word),
        .rd_idx    (out_idx_reg),
        .hash_word (hash_word)
    );

    assign in_ready    = (state_reg == ST_COLLECT);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = hash_word;
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

endmodule

`default_nettype wire

// ===== rtl/shabs_checker.sv =====
// port-level checks for the sha-256 byte stream hasher, bound to the top level
`default_nettype none

module shabs_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] digest_word,
    input  wire logic [2:0]  word_index,
    input  wire logic        last_word
);

    // no new item is taken while a digest is being delivered
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while digest pending");

    // the digest words come back to back in index order
    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=>
            (out_valid && (word_index == $past(word_index) + 3'd1)))
        else $error("digest word sequence broken");

    // last flag marks exactly the eighth word
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // a digest starts at word zero
    a_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 3'd0))
        else $error("digest does not start at word zero");

    // stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
        else $error("digest word changed while stalled");

endmodule

bind sha256_byte_stream_hasher_core shabs_checker u_shabs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);

`default_nettype wire

// ===== tb/tb_sha256_byte_stream_hasher_core.sv =====
// self-checking testbench for the sha-256 byte stream hasher core
module tb_sha256_byte_stream_hasher_core;

    timeunit 1ns;
    timeprecision 1ps;

    // run bounds: the cycle limit allows for the slowest legal run several times over
    localparam int unsigned TARGET_ITEMS = 420;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned REPORT_MAX   = 10;

    // idle percentages per traffic phase: none, sender idle, receiver stall, both
    localparam int unsigned SEND_IDLE_PCT [4] = '{0, 46, 0, 19};
    localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 46, 19};

    // round constants and initial chaining value
    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam bit [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // one input item and one digest word
    typedef struct {
        bit       has_byte;
        bit [7:0] msg_byte;
        bit       is_end;
    } stream_item_t;

    typedef struct {
        bit [31:0] word;
        bit [2:0]  index;
        bit        last;
    } digest_entry_t;

    // dut ports; the inputs are known from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        byte_present = 1'b0;
    logic [7:0]  data_byte    = 8'h00;
    logic        message_end  = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // items still to send and digest words still owed by the dut
    stream_item_t  pending_items[$];
    digest_entry_t owed_digest_words[$];

    int unsigned counted_items;   // items that do something, empty fillers excluded
    int unsigned stim_total;
    int unsigned items_taken;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // predictor state: chaining value, partial block and message length
    bit [31:0] chain_h [8];
    bit [7:0]  block_bytes [64];
    int unsigned block_fill;
    bit [63:0] msg_bit_len;

    sha256_byte_stream_hasher_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_present (byte_present),
        .data_byte    (data_byte),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    // ------------------------------------------------------------------
    // sha-256 predictor
    // ------------------------------------------------------------------

    function automatic bit [31:0] rotr(bit [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        foreach (chain_h[i])
        begin
            chain_h[i] = SHA_IV[i];
        end
        block_fill  = 0;
        msg_bit_len = '0;
    endfunction

    // full 64-round compression of block_bytes into chain_h
    function automatic void compress_block_bytes();
        bit [31:0] w [64];
        bit [31:0] v [8];
        bit [31:0] t1;
        bit [31:0] t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        v = chain_h;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain_h[i] = chain_h[i] + v[i];
        end
    endfunction

    // absorb one accepted item; at message end pad, finish and queue the digest
    function automatic void absorb_stream_item(stream_item_t it);
        digest_entry_t d;
        if (it.has_byte)
        begin
            block_bytes[block_fill] = it.msg_byte;
            block_fill++;
            msg_bit_len += 64'd8;
            if (block_fill == 64)
            begin
                compress_block_bytes();
                block_fill = 0;
            end
        end
        if (!it.is_end)
            return;
        block_bytes[block_fill] = 8'h80;
        block_fill++;
        // no room for the length field: spill into one more block
        if (block_fill > 56)
        begin
            while (block_fill < 64)
            begin
                block_bytes[block_fill] = 8'h00;
                block_fill++;
            end
            compress_block_bytes();
            block_fill = 0;
        end
        while (block_fill < 56)
        begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
        end
        for (int i = 0; i < 8; i++)
        begin
            block_bytes[56+i] = msg_bit_len[63 - 8*i -: 8];
        end
        compress_block_bytes();
        for (int i = 0; i < 8; i++)
        begin
            d.word  = chain_h[i];
            d.index = 3'(i);
            d.last  = (i == 7);
            owed_digest_words.insert(owed_digest_words.size(), d);
        end
        restart_message();
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------

    function automatic void queue_item(bit has_byte, bit [7:0] msg_byte, bit is_end);
        stream_item_t it;
        it.has_byte = has_byte;
        it.msg_byte = msg_byte;
        it.is_end   = is_end;
        pending_items.insert(pending_items.size(), it);
        // fillers with no byte and no end leave the hasher untouched
        if (has_byte || is_end)
            counted_items++;
    endfunction

    // a well-formed message with random content, lengths biased to padding edges
    function automatic void queue_random_message();
        int unsigned edge_lens [12] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
        int unsigned msg_len;
        bit          end_on_byte;
        if ($urandom_range(0, 99) < 35)
            msg_len = edge_lens[$urandom_range(0, 11)];
        else
            msg_len = $urandom_range(0, 30);
        end_on_byte = (msg_len > 0) && $urandom_range(0, 1);
        for (int unsigned i = 0; i < msg_len; i++)
        begin
            // occasional filler item inside the message, its data byte is junk
            if ($urandom_range(0, 9) == 0)
                queue_item(1'b0, 8'($urandom), 1'b0);
            queue_item(1'b1, 8'($urandom), end_on_byte && (i == msg_len - 1));
        end
        if (!end_on_byte)
            queue_item(1'b0, 8'($urandom), 1'b1);
    endfunction

    // traffic phase cycles twice through the four idle patterns as items go in
    function automatic int unsigned traffic_phase();
        if (stim_total == 0)
            return 0;
        return ((items_taken * 8) / stim_total) % 4;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and the main sequence
    // ------------------------------------------------------------------

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        restart_message();

        // empty message straight after reset
        queue_item(1'b0, 8'h5a, 1'b1);
        // fillers with extreme junk bytes change nothing
        queue_item(1'b0, 8'hff, 1'b0);
        queue_item(1'b0, 8'h00, 1'b0);
        // short text message, end flag rides on the last byte
        queue_item(1'b1, 8'h61, 1'b0);
        queue_item(1'b1, 8'h62, 1'b0);
        queue_item(1'b1, 8'h63, 1'b1);
        // byte extremes, end on a separate empty item
        queue_item(1'b1, 8'h00, 1'b0);
        queue_item(1'b1, 8'hff, 1'b0);
        queue_item(1'b0, 8'ha5, 1'b1);
        // single byte message with the end on the byte
        queue_item(1'b1, 8'hff, 1'b1);
        // back to back empty messages
        queue_item(1'b0, 8'h00, 1'b1);
        queue_item(1'b0, 8'hff, 1'b1);

        while (counted_items < TARGET_ITEMS)
            queue_random_message();
        stim_total = pending_items.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // every item accepted
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        // every owed digest word delivered
        while (owed_digest_words.size() != 0)
            @(posedge clk);
        // let any stray output show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && owed_digest_words.size() == 0)
            $display("sha256_byte_stream_hasher_core verification clean");
        else
            $display("sha256_byte_stream_hasher_core verification failed");
        $finish;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sha256_byte_stream_hasher_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // input driver: valid holds with a steady payload until the handshake
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : input_driver
        stream_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            // the item on the port was taken at this edge: feed the predictor
            if (in_valid)
            begin
                nxt.has_byte = byte_present;
                nxt.msg_byte = data_byte;
                nxt.is_end   = message_end;
                absorb_stream_item(nxt);
                items_taken++;
            end
            if (pending_items.size() != 0
                && $urandom_range(0, 99) >= SEND_IDLE_PCT[traffic_phase()])
            begin
                nxt = pending_items.pop_front();
                in_valid     <= 1'b1;
                byte_present <= nxt.has_byte;
                data_byte    <= nxt.msg_byte;
                message_end  <= nxt.is_end;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[traffic_phase()]);
    end

    // ------------------------------------------------------------------
    // output monitor: each delivered word against the oldest owed one
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : digest_monitor
        digest_entry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_digest_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected digest word: word %h index %0d last %b",
                             digest_word, word_index, last_word);
            end
            else
            begin
                want = owed_digest_words.pop_front();
                if (digest_word !== want.word || word_index !== want.index
                    || last_word !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("digest mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                                 want.word, want.index, want.last,
                                 digest_word, word_index, last_word);
                end
            end
        end
    end

endmodule
